/* hdl/start_token_length_deframer_defines.svh */
// Assertion macros shared by the deframer modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef START_TOKEN_LENGTH_DEFRAMER_DEFINES_SVH
`define START_TOKEN_LENGTH_DEFRAMER_DEFINES_SVH

// Condition that must hold at every clock edge.
`define STLD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define STLD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* hdl/stld_pkg.sv */
// Shared types and constants of the start-token length deframer.
// No dependencies; every module file imports this package.
package stld_pkg;

  localparam int LENGTH_WIDTH_DEF = 32;

  localparam int TOKEN_BYTES = 8;
  localparam logic [7:0] TOKEN [TOKEN_BYTES] = '{
    8'h40, 8'h4D, 8'h79, 8'h50, 8'h52, 8'h4F, 8'h58, 8'h59
  };

  localparam logic [63:0] HEADER_BYTES = 64'd16;
  localparam logic [31:0] MAX_FRAME_LEN_RESET = 32'd524288000;

  // Result event codes.
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_EMPTY    = 2'd1;
  localparam logic [1:0] EV_OVERSIZE = 2'd2;
  localparam logic [1:0] EV_SHORT    = 2'd3;

  // Configuration address map.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_FRAME_LEN = '0;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        frame_start;
    logic        frame_end;
    logic [1:0]  event_code;
    logic [31:0] payload_length;
  } result_t;

  typedef struct packed {
    logic [2:0] hunt_next;
    logic       hunt_full;
    logic [2:0] rescan_next;
    logic       rescan_full;
  } match_t;

endpackage

/* hdl/stld_token_match.sv */
// Start token matcher: one-byte step of the hunt and a parallel rescan of
// the eight length bytes after a dropped frame. Depends on stld_pkg.
module stld_token_match import stld_pkg::*; (
  input  logic [2:0]  matched,
  input  logic [7:0]  cur_byte,
  input  logic [55:0] prior_bytes,
  output match_t      match
);

  logic [63:0]            window;
  logic [TOKEN_BYTES:1]   suffix_hit;
  logic                   hit;

  assign window = {cur_byte, prior_bytes};

  // The token has no proper border, so the matcher state after a rescan is the
  // longest suffix of the eight bytes that is also a prefix of the token.
  always_comb begin
    for (int k = 1; k <= TOKEN_BYTES; k++) begin
      suffix_hit[k] = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (window[8*(TOKEN_BYTES-k+j) +: 8] != TOKEN[j]) begin
          suffix_hit[k] = 1'b0;
        end
      end
    end
  end

  assign hit = (cur_byte == TOKEN[matched]);

  always_comb begin
    match.rescan_next = 3'd0;
    for (int k = 1; k < TOKEN_BYTES; k++) begin
      if (suffix_hit[k]) begin
        match.rescan_next = 3'(k);
      end
    end
    match.rescan_full = suffix_hit[TOKEN_BYTES];
    match.hunt_next   = hit ? (matched + 3'd1) : {2'b00, (cur_byte == TOKEN[0])};
    match.hunt_full   = hit && (matched == 3'd7);
  end

endmodule

/* hdl/stld_frame_ctrl.sv */
// Input word register, frame state and result formation of the deframer.
// Depends on stld_pkg, stld_token_match and the assertion macro header.
`include "start_token_length_deframer_defines.svh"

module stld_frame_ctrl import stld_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] max_frame_length,
  input  logic        room,
  output logic        res_push,
  output result_t     res
);

  localparam int CNT_W = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic             byte_full;
  logic [7:0]       byte_q;
  logic [1:0]       phase, phase_next;
  logic [2:0]       matched, matched_next;
  logic [2:0]       len_cnt, len_cnt_next;
  logic [55:0]      len_bytes, len_bytes_next;
  logic [CNT_W-1:0] payload_left, payload_left_next;
  logic [CNT_W-1:0] frame_len, frame_len_next;

  logic             adv;
  match_t           match;
  logic [63:0]      total;
  logic [63:0]      payload;
  logic             short_len, over_max, cnt_ovf, empty_len;
  logic [31:0]      plen_sat;
  logic [CNT_W-1:0] left_dec;

  assign adv        = byte_full && room;
  assign byte_ready = !byte_full || room;

  stld_token_match u_match (
    .matched     (matched),
    .cur_byte    (byte_q),
    .prior_bytes (len_bytes),
    .match       (match)
  );

  assign total     = {byte_q, len_bytes};
  assign payload   = total - HEADER_BYTES;
  assign short_len = (total < HEADER_BYTES);
  assign over_max  = (|total[63:32]) || (total[31:0] > max_frame_length);
  assign cnt_ovf   = ((payload[31:0] >> CNT_W) != 32'd0);
  assign empty_len = (total == HEADER_BYTES);
  assign plen_sat  = (|payload[63:32]) ? 32'hFFFF_FFFF : payload[31:0];
  assign left_dec  = (payload_left != '0) ? (payload_left - CNT_W'(1)) : payload_left;

  always_comb begin
    phase_next        = phase;
    matched_next      = matched;
    len_cnt_next      = len_cnt;
    len_bytes_next    = len_bytes;
    payload_left_next = payload_left;
    frame_len_next    = frame_len;
    res_push          = 1'b0;
    res               = '0;
    if (adv) begin
      case (phase)
        PH_LEN: begin
          len_bytes_next = {byte_q, len_bytes[55:8]};
          if (len_cnt != 3'd7) begin
            len_cnt_next = len_cnt + 3'd1;
          end else begin
            len_cnt_next = 3'd0;
            if (short_len || over_max || cnt_ovf) begin
              res_push            = 1'b1;
              res.event_code      = short_len ? EV_SHORT : EV_OVERSIZE;
              res.payload_length  = short_len ? 32'd0 : plen_sat;
              // A dropped frame resumes the hunt over its own length bytes.
              phase_next   = match.rescan_full ? PH_LEN : PH_HUNT;
              matched_next = match.rescan_full ? 3'd0 : match.rescan_next;
            end else if (empty_len) begin
              res_push          = 1'b1;
              res.event_code    = EV_EMPTY;
              res.frame_end     = 1'b1;
              phase_next        = PH_HUNT;
              matched_next      = 3'd0;
              frame_len_next    = '0;
              payload_left_next = '0;
            end else begin
              frame_len_next    = payload[CNT_W-1:0];
              payload_left_next = payload[CNT_W-1:0];
              phase_next        = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          res_push           = 1'b1;
          res.payload_byte   = byte_q;
          res.frame_start    = (payload_left == frame_len);
          res.frame_end      = (payload_left <= CNT_W'(1));
          res.event_code     = EV_PAYLOAD;
          res.payload_length = 32'(frame_len);
          payload_left_next  = left_dec;
          if (left_dec == '0) begin
            phase_next   = PH_HUNT;
            matched_next = 3'd0;
          end
        end
        default: begin
          phase_next   = PH_HUNT;
          matched_next = match.hunt_next;
          if (match.hunt_full) begin
            phase_next   = PH_LEN;
            len_cnt_next = 3'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full    <= 1'b0;
      phase        <= PH_HUNT;
      matched      <= 3'd0;
      len_cnt      <= 3'd0;
      payload_left <= '0;
      frame_len    <= '0;
    end else begin
      if (byte_valid && byte_ready) begin
        byte_full <= 1'b1;
      end else if (adv) begin
        byte_full <= 1'b0;
      end
      phase        <= phase_next;
      matched      <= matched_next;
      len_cnt      <= len_cnt_next;
      payload_left <= payload_left_next;
      frame_len    <= frame_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      byte_q <= data_byte;
    end
    len_bytes <= len_bytes_next;
  end

  `STLD_ASSERT_NEXT(a_token_starts_len, adv && (phase != PH_LEN) && (phase != PH_PAY) && match.hunt_full, phase == PH_LEN, "full token did not start the length phase")
  `STLD_ASSERT_ALWAYS(a_left_bounded, payload_left <= frame_len, "payload count exceeds frame length")
  `STLD_ASSERT_ALWAYS(a_pay_nonzero, (phase != PH_PAY) || (payload_left != '0), "payload phase with nothing left")

endmodule

/* hdl/stld_out_buf.sv */
// Two-entry result buffer: an output register plus a skid register, so the
// processing stage never waits on result_ready directly. Depends on stld_pkg.
`include "start_token_length_deframer_defines.svh"

module stld_out_buf import stld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    pop;

  assign pop          = out_valid && result_ready;
  assign room         = !skid_valid;
  assign result_valid = out_valid;
  assign result       = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  `STLD_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid, "skid word held with empty output register")
  `STLD_ASSERT_ALWAYS(a_no_push_when_full, !push || !skid_valid, "result pushed into a full buffer")
  `STLD_ASSERT_NEXT(a_hold, out_valid && !result_ready, out_valid && $stable(out_data), "stalled word changed")

endmodule

/* hdl/stld_cfg_regs.sv */
// Configuration register block on the APB-style port: the frame length limit.
// Depends on stld_pkg.
module stld_cfg_regs import stld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [31:0]           max_frame_length
);

  logic [CFG_ADDR_W-3:0] reg_index;
  logic                  sel_max;

  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign sel_max   = (reg_index == REG_MAX_FRAME_LEN);
  assign pready    = 1'b1;
  assign prdata    = sel_max ? max_frame_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_LEN_RESET;
    end else if (psel && penable && pwrite && pready && sel_max) begin
      max_frame_length <= pwdata;
    end
  end

endmodule

/* hdl/start_token_length_deframer.sv */
// Start token length deframer: byte stream in, payload words and frame events
// out. An incoming byte word is accepted on byte_valid and byte_ready high.
// The block hunts for the 8-byte start token, reads the 8-byte little-endian
// total length (header of 16 bytes included) and then passes the payload out
// one byte per result word, marking the first and the last byte.
// A length below 16 or above max_frame_length gives one drop word and the hunt
// resumes over the length bytes; a length of exactly 16 gives an empty-frame
// word. All other bytes produce no result word.
// An accepted byte is held in the input word register, and its result word is
// registered in the output buffer. Throughput: one byte per cycle while the
// output buffer has room for another word.
// The receiver may stall: a two-word output buffer absorbs one word, and
// byte_ready drops only while both words are held, so it never depends
// combinationally on result_ready.
// Reset (rst, synchronous) empties all stages, restarts the hunt and sets the
// length limit to 524288000. Configuration is written through the APB port.
module start_token_length_deframer import stld_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  logic [7:0]            data_byte,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [7:0]            payload_byte,
  output logic                  frame_start,
  output logic                  frame_end,
  output logic [1:0]            event_code,
  output logic [31:0]           payload_length,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] max_frame_length;
  logic        room;
  logic        res_push;
  result_t     res;
  result_t     result;

  stld_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .max_frame_length (max_frame_length)
  );

  stld_frame_ctrl #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .data_byte        (data_byte),
    .max_frame_length (max_frame_length),
    .room             (room),
    .res_push         (res_push),
    .res              (res)
  );

  stld_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (res_push),
    .push_data    (res),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign payload_byte   = result.payload_byte;
  assign frame_start    = result.frame_start;
  assign frame_end      = result.frame_end;
  assign event_code     = result.event_code;
  assign payload_length = result.payload_length;

endmodule

/* bench/start_token_length_deframer_tb.sv */
// Self-checking bench for start_token_length_deframer: byte words are framed
// with the start token and a length, and every result word is checked against
// an in-bench model. Depends only on stld_pkg and the deframer RTL.
module start_token_length_deframer_tb;
  import stld_pkg::*;

  typedef enum logic [1:0] {HUNTING, READING_LEN, IN_PAYLOAD} hunt_phase_e;

  localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_FRAME_LEN, 2'b00};
  localparam logic [63:0] COUNT_LIMIT = 64'h0000_0000_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  logic [7:0] data_byte = 8'h00;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [7:0] payload_byte;
  logic frame_start;
  logic frame_end;
  logic [1:0] event_code;
  logic [31:0] payload_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic pready;

  // Model state of the deframer.
  hunt_phase_e phase_q = HUNTING;
  int unsigned tok_hits = 0;
  int unsigned len_count = 0;
  logic [63:0] len_acc = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] frame_len = '0;
  logic [31:0] max_len_cfg = MAX_FRAME_LEN_RESET;

  result_t expected_words[$];
  int failures = 0;
  int sent_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  start_token_length_deframer uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .payload_byte(payload_byte),
    .frame_start(frame_start),
    .frame_end(frame_end),
    .event_code(event_code),
    .payload_length(payload_length),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // Advance the token matcher. A mismatch falls back to one matched byte when
  // the byte is the first token byte, since no proper prefix is also a suffix.
  function automatic void match_token(input logic [7:0] b);
    int unsigned m;
    m = tok_hits & 7;
    if (b == TOKEN[m]) begin
      tok_hits = m + 1;
    end else begin
      tok_hits = (b == TOKEN[0]) ? 1 : 0;
    end
    if (tok_hits >= TOKEN_BYTES) begin
      tok_hits = 0;
      phase_q = READING_LEN;
      len_count = 0;
      len_acc = '0;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [63:0] total;
    logic [63:0] plen;
    logic [1:0] code;
    result_t r;
    int i;
    r = '0;
    if (phase_q == READING_LEN) begin
      len_acc = {b, len_acc[63:8]};
      if (len_count < 7) begin
        len_count++;
        return;
      end
      len_count = 0;
      total = len_acc;
      if (total < HEADER_BYTES) begin
        code = EV_SHORT;
        plen = '0;
      end else if (total > {32'd0, max_len_cfg} || total - HEADER_BYTES > COUNT_LIMIT) begin
        code = EV_OVERSIZE;
        plen = total - HEADER_BYTES;
        if (plen > COUNT_LIMIT) plen = COUNT_LIMIT;
      end else if (total == HEADER_BYTES) begin
        phase_q = HUNTING;
        tok_hits = 0;
        frame_len = '0;
        bytes_left = '0;
        r.frame_end = 1'b1;
        r.event_code = EV_EMPTY;
        expected_words.push_back(r);
        return;
      end else begin
        frame_len = 32'(total - HEADER_BYTES);
        bytes_left = frame_len;
        phase_q = IN_PAYLOAD;
        return;
      end
      // A dropped frame restarts the hunt over its own length bytes.
      phase_q = HUNTING;
      tok_hits = 0;
      for (i = 0; i < 8; i++) begin
        if (phase_q == HUNTING) begin
          match_token(total[8*i +: 8]);
        end else begin
          len_acc = {total[8*i +: 8], len_acc[63:8]};
          len_count++;
        end
      end
      r.event_code = code;
      r.payload_length = plen[31:0];
      expected_words.push_back(r);
    end else if (phase_q == IN_PAYLOAD) begin
      r.payload_byte = b;
      r.frame_start = (bytes_left == frame_len);
      r.frame_end = (bytes_left <= 1);
      r.event_code = EV_PAYLOAD;
      r.payload_length = frame_len;
      expected_words.push_back(r);
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) begin
        phase_q = HUNTING;
        tok_hits = 0;
      end
    end else begin
      match_token(b);
    end
  endfunction

  // Returns at the edge where the word was accepted, with valid still high.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    deframe_byte(b);
    sent_count++;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  task automatic send_token();
    int j;
    for (j = 0; j < TOKEN_BYTES; j++) send_byte(TOKEN[j]);
  endtask

  task automatic send_length(input logic [63:0] total);
    int j;
    for (j = 0; j < 8; j++) send_byte(total[8*j +: 8]);
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_max_len_reg();
    psel <= 1'b1;
    paddr <= MAX_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== max_len_cfg) begin
      $error("prdata: expected %0h, got %0h", max_len_cfg, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_max_len(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_LEN_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    max_len_cfg = v;
    check_max_len_reg();
  endtask

  // Accepted lengths stay small so that no frame holds the block for long.
  function automatic logic [63:0] pick_frame_total();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return HEADER_BYTES;
    if (sel < 20 && max_len_cfg <= 100)
      return {32'd0, max_len_cfg} + 64'($urandom_range(0, 1));
    if (sel < 25) return 64'($urandom_range(0, 15));
    if (sel < 30) return {$urandom | 32'h1, $urandom};
    if (sel < 33) return {32'd0, max_len_cfg} + 64'd1;
    if (sel < 90) return HEADER_BYTES + 64'($urandom_range(1, 24));
    return HEADER_BYTES + 64'($urandom_range(25, 64));
  endfunction

  // Bring the block back to hunting: finish a payload with random words,
  // and complete a length with all-ones bytes, which always drops.
  task automatic return_to_hunt();
    while (phase_q == IN_PAYLOAD) send_byte(8'($urandom_range(0, 255)));
    while (phase_q == READING_LEN) send_byte(8'hFF);
  endtask

  task automatic run_random(input int n_items, input bit allow_idle);
    int stop_at;
    int unsigned kind;
    int j;
    int k;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      return_to_hunt();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_token();
        send_length(pick_frame_total());
        j = 0;
        while (phase_q == IN_PAYLOAD) begin
          send_byte(($urandom_range(0, 9) == 0) ? TOKEN[j % 8] : 8'($urandom_range(0, 255)));
          j++;
        end
      end else if (kind < 80) begin
        k = $urandom_range(1, 10);
        for (j = 0; j < k; j++)
          send_byte($urandom_range(0, 1) ? TOKEN[$urandom_range(0, 7)]
                                         : 8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        k = $urandom_range(1, 7);
        for (j = 0; j < k; j++) send_byte(TOKEN[j]);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_token();
        k = $urandom_range(1, 7);
        for (j = 0; j < k; j++) send_byte(8'($urandom_range(0, 255)));
      end
    end
    return_to_hunt();
    wait_idle();
  endtask

  task automatic test_directed_frames();
    logic [63:0] tok_len;
    int j;
    idle_on = 1'b1;
    check_max_len_reg();
    send_byte(8'h00);
    send_byte(8'hFF);
    // A broken token followed by a fresh one: the match restarts on the '@'.
    send_byte(TOKEN[0]);
    send_byte(TOKEN[1]);
    send_token();
    send_length(64'd17);
    send_byte(8'h00);
    send_token();
    send_length(64'd18);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_token();
    send_length(HEADER_BYTES);
    send_token();
    send_length(64'd0);
    send_token();
    send_length(64'd15);
    send_token();
    send_length('1);
    send_token();
    send_length({32'd0, MAX_FRAME_LEN_RESET} + 64'd1);
    // A dropped length that is itself the token starts a new length phase.
    for (j = 0; j < 8; j++) tok_len[8*j +: 8] = TOKEN[j];
    send_token();
    send_length(tok_len);
    send_length(64'd17);
    send_byte(8'hA5);
    wait_idle();
  endtask

  task automatic test_min_limit();
    write_max_len(32'd16);
    run_random(200, 1'b1);
  endtask

  task automatic test_mid_limit();
    write_max_len(32'($urandom_range(17, 48)));
    run_random(200, 1'b1);
    write_max_len(32'($urandom_range(17, 100)));
    run_random(200, 1'b1);
  endtask

  task automatic test_max_limit();
    write_max_len(32'hFFFF_FFFF);
    run_random(400, 1'b1);
  endtask

  task automatic test_reset_limit_tail();
    write_max_len(MAX_FRAME_LEN_RESET);
    run_random(330, 1'b0);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 18);
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: event_code %0d", event_code);
        failures++;
      end else begin
        want = expected_words.pop_front();
        if (payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
          failures++;
        end
        if (frame_start !== want.frame_start) begin
          $error("frame_start: expected %0b, got %0b", want.frame_start, frame_start);
          failures++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          failures++;
        end
        if (event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, event_code);
          failures++;
        end
        if (payload_length !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 payload_length);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_min_limit();
    test_mid_limit();
    test_max_limit();
    test_reset_limit_tail();
    if (failures == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
